>>> design/jcq_pkg.sv
// Shared types, the per-step reciprocal table and opcode constants of the coefficient quantizer.
package jcq_pkg;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_QUANT   = 2'd1,
      OP_DEQUANT = 2'd2,
      OP_UNUSED  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [15:0] recip;
      logic [11:0] round;
      logic [4:0]  shift;
   } quant_entry_type;

   typedef quant_entry_type [255:0] quant_table_type;

   typedef struct packed {
      logic               valid;
      logic               quant;
      logic [5:0]         position;
      logic signed [15:0] coefficient;
   } stage_ctrl_type;

   function automatic quant_entry_type derive_entry(input logic [7:0] step);
      quant_entry_type e;
      logic [24:0] num;
      logic [24:0] q;
      logic [8:0]  rem;
      logic [3:0]  len;
      logic [5:0]  r;
      logic [11:0] c;
      len = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (step[i]) begin
            len = 4'(i + 1);
         end
      end
      num = 25'd1 << (15 + len);
      q = '0;
      rem = '0;
      for (int i = 24; i >= 0; i--) begin
         rem = {rem[7:0], num[i]};
         if (rem >= {1'b0, step}) begin
            rem = rem - {1'b0, step};
            q[i] = 1'b1;
         end
      end
      r = 6'(19 + len);
      c = {1'b0, step, 3'b000};
      if (rem == 9'd0) begin
         q = q >> 1;
         r = r - 6'd1;
      end else if ({rem[7:0], 1'b0} <= {1'b0, step}) begin
         c = c + 12'd1;
      end else begin
         q = q + 25'd1;
      end
      e.recip = q[15:0];
      e.round = c;
      e.shift = r[4:0];
      return e;
   endfunction

   function automatic quant_table_type build_table();
      quant_table_type t;
      for (int s = 0; s < 256; s++) begin
         t[s] = derive_entry((s == 0) ? 8'd1 : 8'(s));
      end
      return t;
   endfunction

   localparam quant_table_type QUANT_TABLE = build_table();

endpackage

>>> design/jcq_step_mem.sv
// Step memory with one write port and one registered read port.
module jcq_step_mem #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_idx,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_idx,
   output logic [7:0]               rd_data_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

endmodule

>>> design/jcq_arith.sv
// Quantize and dequantize datapath: table lookup, multiply and shift stages.
module jcq_arith (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  jcq_pkg::stage_ctrl_type s1,
   input  logic [7:0]              s1_step,
   output logic                    rsp_valid_ff,
   output logic signed [15:0]      rsp_value_ff,
   output logic [5:0]              rsp_position_ff
);

   logic               s2_valid_ff;
   logic               s2_quant_ff;
   logic               s2_neg_ff;
   logic [5:0]         s2_pos_ff;
   logic [17:0]        s2_sum_ff;
   logic [15:0]        s2_recip_ff;
   logic [4:0]         s2_shift_ff;
   logic [15:0]        s2_coef_ff;
   logic [7:0]         s2_step_ff;

   logic               s3_valid_ff;
   logic               s3_quant_ff;
   logic               s3_neg_ff;
   logic [5:0]         s3_pos_ff;
   logic [4:0]         s3_shift_ff;
   logic [33:0]        s3_prod_ff;
   logic [15:0]        s3_deq_ff;

   jcq_pkg::quant_entry_type entry;
   logic [16:0]        mag;
   logic [17:0]        s2_sum_in;
   logic [23:0]        deq_full;
   logic [33:0]        shifted;
   logic [15:0]        y16;
   logic [15:0]        rsp_value_in;

   always_comb begin
      entry = jcq_pkg::QUANT_TABLE[s1_step];
      if (s1.coefficient[15]) begin
         mag = 17'h10000 - {1'b0, s1.coefficient};
      end else begin
         mag = {1'b0, s1.coefficient};
      end
      s2_sum_in = {1'b0, mag} + {6'd0, entry.round};
      deq_full = {8'd0, s2_coef_ff} * {16'd0, s2_step_ff};
      shifted = s3_prod_ff >> s3_shift_ff;
      y16 = shifted[15:0];
      if (s3_quant_ff) begin
         rsp_value_in = s3_neg_ff ? 16'(~y16 + 16'd1) : y16;
      end else begin
         rsp_value_in = s3_deq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= s1.valid;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_quant_ff     <= s1.quant;
         s2_neg_ff       <= s1.coefficient[15];
         s2_pos_ff       <= s1.position;
         s2_sum_ff       <= s2_sum_in;
         s2_recip_ff     <= entry.recip;
         s2_shift_ff     <= entry.shift;
         s2_coef_ff      <= s1.coefficient;
         s2_step_ff      <= s1_step;
         s3_quant_ff     <= s2_quant_ff;
         s3_neg_ff       <= s2_neg_ff;
         s3_pos_ff       <= s2_pos_ff;
         s3_shift_ff     <= s2_shift_ff;
         s3_prod_ff      <= {16'd0, s2_sum_ff} * {18'd0, s2_recip_ff};
         s3_deq_ff       <= deq_full[15:0];
         rsp_value_ff    <= rsp_value_in;
         rsp_position_ff <= s3_pos_ff;
      end
   end

`ifndef SYNTHESIS
   a_s2_to_s3 : assert property (@(posedge clock) disable iff (reset)
      advance && s2_valid_ff |=> s3_valid_ff)
      else $error("item lost between stage two and stage three");
   a_s3_to_out : assert property (@(posedge clock) disable iff (reset)
      advance && s3_valid_ff |=> rsp_valid_ff)
      else $error("item lost before the output register");
   a_hold_prod : assert property (@(posedge clock) disable iff (reset)
      !advance && s3_valid_ff |=> $stable(s3_prod_ff) && $stable(s3_valid_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule

>>> design/jpeg_coeff_quantizer_top.sv
// Top level of the JPEG coefficient quantizer: input stage, step memory and datapath.
// Each item passes through four register stages (input and step read, reciprocal table
// lookup with rounding add, 18x16 multiply, shift and sign restore), and one item is
// taken per cycle when the output is not stalled. A load writes the step memory and
// gives no result; quantize and dequantize give one result each. An output stall holds
// the whole pipeline.
module jpeg_coeff_quantizer_top #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [5:0]         req_position,
   input  logic signed [15:0] req_coefficient,
   input  logic [7:0]         req_step_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_result_value,
   output logic [5:0]         rsp_result_position
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam logic [8:0] ENTRIES9 = 9'(TABLE_ENTRIES);

   logic                    advance;
   logic                    accept;
   logic [8:0]              idx_wide;
   logic [IW-1:0]           idx;
   logic [7:0]              step_wr;
   logic [7:0]              step_rd;
   jcq_pkg::stage_ctrl_type s1_ff;
   jcq_pkg::stage_ctrl_type s1_in;
   logic                    out_valid;

   always_comb begin
      advance = !out_valid || !rsp_stall;
      req_stall = !advance;
      accept = req_valid && advance;
      idx_wide = {3'd0, req_position};
      for (int k = 0; k < 4; k++) begin
         if (idx_wide >= ENTRIES9) begin
            idx_wide = idx_wide - ENTRIES9;
         end
      end
      idx = idx_wide[IW-1:0];
      step_wr = (req_step_value == 8'd0) ? 8'd1 : req_step_value;
      s1_in.valid = accept && (req_opcode == jcq_pkg::OP_QUANT
                               || req_opcode == jcq_pkg::OP_DEQUANT);
      s1_in.quant = (req_opcode == jcq_pkg::OP_QUANT);
      s1_in.position = req_position;
      s1_in.coefficient = req_coefficient;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff.valid <= s1_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff.quant       <= s1_in.quant;
         s1_ff.position    <= s1_in.position;
         s1_ff.coefficient <= s1_in.coefficient;
      end
   end

   jcq_step_mem #(.DEPTH(TABLE_ENTRIES)) u_mem (
      .clock      (clock),
      .wr_en      (accept && req_opcode == jcq_pkg::OP_LOAD),
      .wr_idx     (idx),
      .wr_data    (step_wr),
      .rd_en      (advance),
      .rd_idx     (idx),
      .rd_data_ff (step_rd)
   );

   jcq_arith u_arith (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .s1              (s1_ff),
      .s1_step         (step_rd),
      .rsp_valid_ff    (out_valid),
      .rsp_value_ff    (rsp_result_value),
      .rsp_position_ff (rsp_result_position)
   );

   assign rsp_valid = out_valid;

endmodule
